@@ sv/cbm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared sizes, entry kinds, action and error codes of the chained block
// multimap.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // store geometry
  localparam int unsigned KEY_COUNT    = 1024;
  localparam int unsigned POOL_ENTRIES = 32768;
  localparam int unsigned STORE_DEPTH  = KEY_COUNT + POOL_ENTRIES;
  localparam int unsigned MAX_EMIT     = 16;
  localparam int unsigned WALK_LIMIT   = 2 * STORE_DEPTH;
  localparam int unsigned FRAME_MAX    = POOL_ENTRIES / 2 + 1;

  // field widths
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned KEY_W   = 10;
  localparam int unsigned LOC_W   = 16;
  localparam int unsigned VAL_W   = 57;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned ERR_W   = 2;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned STEP_W  = 17;
  localparam int unsigned FRAME_W = 15;
  localparam int unsigned EMIT_W  = 5;
  localparam int unsigned BS_W    = 7;

  // entry kinds (code 7 is never written and reads as end)
  localparam logic [2:0] K_EMPTY    = 3'd0;
  localparam logic [2:0] K_REF      = 3'd1;
  localparam logic [2:0] K_END      = 3'd2;
  localparam logic [2:0] K_LIVE     = 3'd3;
  localparam logic [2:0] K_LIVE_END = 3'd4;
  localparam logic [2:0] K_TOMB     = 3'd5;
  localparam logic [2:0] K_TOMB_END = 3'd6;

  // actions
  localparam logic [ACT_W-1:0] A_INSERT  = 3'd0;
  localparam logic [ACT_W-1:0] A_ITERATE = 3'd1;
  localparam logic [ACT_W-1:0] A_READ    = 3'd2;
  localparam logic [ACT_W-1:0] A_SETST   = 3'd3;
  localparam logic [ACT_W-1:0] A_CMPST   = 3'd4;
  localparam logic [ACT_W-1:0] A_CUPD    = 3'd5;
  localparam logic [ACT_W-1:0] A_DELETE  = 3'd6;
  localparam logic [ACT_W-1:0] A_CDELETE = 3'd7;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_POOL   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ACCESS = 2'd2;

  // config register index (byte address bit 2)
  localparam logic REG_BLK_LEN = 1'b0;

endpackage

`default_nettype wire

@@ sv/cbm_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_in_if / cbm_out_if
// Valid/ready channels carrying multimap requests and results.
// ----------------------------------------------------------------------------
interface cbm_in_if
  import cbm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [KEY_W-1:0] key;
  logic [LOC_W-1:0] location;
  logic             from_location;
  logic [VAL_W-1:0] new_value;
  logic [ST_W-1:0]  new_status;
  logic [VAL_W-1:0] expect_value;
  logic [ST_W-1:0]  expect_status;

  modport source (output valid, action, key, location, from_location, new_value,
                  new_status, expect_value, expect_status, input ready);
  modport sink (input valid, action, key, location, from_location, new_value,
                new_status, expect_value, expect_status, output ready);
endinterface

interface cbm_out_if
  import cbm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [LOC_W-1:0] result_location;
  logic [VAL_W-1:0] entry_value;
  logic [ST_W-1:0]  entry_status;
  logic             entry_live;
  logic             more_pending;
  logic             success;
  logic [ERR_W-1:0] error_code;
  logic             last_result;

  modport source (output valid, result_location, entry_value, entry_status,
                  entry_live, more_pending, success, error_code, last_result,
                  input ready);
  modport sink (input valid, result_location, entry_value, entry_status,
                entry_live, more_pending, success, error_code, last_result,
                output ready);
endinterface

`default_nettype wire

@@ sv/chained_block_multimap_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chained_block_multimap_top
// Multimap of (value, status) entries per key in one single-port store, with
// a bump-allocated pool of overflow blocks, walked by a small sequencer.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole store to empty, one entry per cycle,
// and takes no request meanwhile; block length writes are taken. It then
// works on one request at a time. Every step of a walk is a registered read
// on the single store port, then an evaluate and maybe a write, and every
// result passes through the output register. Insert and iterate take a step
// per entry walked or reference followed (a moved entry's new place is walked
// again once it is put back); insert adds a step per new block and one per
// moved entry put back, iterate adds a step per emitted entry.
module chained_block_multimap_top
  import cbm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  cbm_in_if.sink           in_i,
  cbm_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_INS, S_MARK, S_POP, S_ITER, S_PE, S_OUT
  } state_e;

  typedef enum logic [1:0] {RET_WALK, RET_FINAL, RET_DONE} ret_e;

  typedef struct packed {
    logic [LOC_W-1:0] loc;
    logic [VAL_W-1:0] val;
    logic [ST_W-1:0]  st;
    logic             live;
    logic             more;
    logic             succ;
    logic [ERR_W-1:0] err;
    logic             last;
  } res_t;

  localparam int unsigned FRAME_BITS = LOC_W + VAL_W + ST_W;

  function automatic res_t mk_res(logic [LOC_W-1:0] loc, logic [VAL_W-1:0] val,
                                  logic [ST_W-1:0] st, logic live, logic more,
                                  logic succ, logic [ERR_W-1:0] err, logic last);
    res_t r;
    r.loc = loc; r.val = val; r.st = st; r.live = live;
    r.more = more; r.succ = succ; r.err = err; r.last = last;
    return r;
  endfunction

  // registers
  state_e           state_q, state_d;
  ret_e             ret_q, ret_d;
  logic [LOC_W-1:0] loc_q, loc_d, clr_q, clr_d, mark_q, mark_d;
  logic [VAL_W-1:0] v_q, v_d, nv_q, nv_d, evx_q, evx_d;
  logic [ST_W-1:0]  s_q, s_d, ns_q, ns_d, esx_q, esx_d;
  logic [ACT_W-1:0] act_q, act_d;
  logic [FRAME_W-1:0] depth_q, depth_d;
  logic [STEP_W-1:0]  steps_q, steps_d;
  logic [LOC_W-1:0]   pool_q, pool_d;
  logic [EMIT_W-1:0]  emit_q, emit_d;
  logic first_q, first_d, refd_q, refd_d, more_q, more_d, ov_q, ov_d;
  res_t r_q, r_d, out_q, out_d;
  logic [BS_W-1:0] bsz_q;

  // store and frame stack
  logic [ENTRY_W-1:0]    st_mem [STORE_DEPTH];
  logic [ENTRY_W-1:0]    e_q;
  logic                  st_we, st_re;
  logic [LOC_W-1:0]      st_addr;
  logic [ENTRY_W-1:0]    st_wdata;
  logic [FRAME_BITS-1:0] fr_mem [FRAME_MAX];
  logic [FRAME_BITS-1:0] fr_q;
  logic                  fr_we, fr_re;
  logic [FRAME_W-1:0]    fr_addr;
  logic [FRAME_BITS-1:0] fr_wdata;

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_addr] <= st_wdata;
    if (st_re) e_q <= st_mem[st_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fr_we) fr_mem[fr_addr] <= fr_wdata;
    if (fr_re) fr_q <= fr_mem[fr_addr];
  end

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLK_LEN) ? {25'd0, bsz_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsz_q <= 7'd4;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BLK_LEN) begin
      bsz_q <= pwdata[BS_W-1:0];
    end
  end

  // decoded fields of the entry just read
  logic [2:0]       kind;
  logic [VAL_W-1:0] e_val;
  logic [ST_W-1:0]  e_st;
  logic [LOC_W-1:0] e_tgt;
  logic [BS_W-1:0]  bs;
  logic             live, tomb, slot_free;

  always_comb begin
    kind  = (e_q[2:0] == 3'd7) ? K_END : e_q[2:0];
    e_val = e_q[62:6];
    e_st  = e_q[5:3];
    e_tgt = (e_val >= VAL_W'(STORE_DEPTH)) ? LOC_W'(STORE_DEPTH) : e_val[LOC_W-1:0];
    live  = (kind == K_LIVE) || (kind == K_LIVE_END);
    tomb  = (kind == K_TOMB) || (kind == K_TOMB_END);
    if (bsz_q < 7'd2) bs = 7'd2;
    else if (bsz_q > 7'd64) bs = 7'd64;
    else bs = bsz_q;
  end

  assign slot_free = !ov_q || out_o.ready;

  // sequencer
  always_comb begin
    logic [2:0]       kk;
    logic             ok;
    logic [LOC_W-1:0] blk;
    state_d = state_q; ret_d = ret_q; loc_d = loc_q; clr_d = clr_q; mark_d = mark_q;
    v_d = v_q; s_d = s_q; nv_d = nv_q; ns_d = ns_q; evx_d = evx_q; esx_d = esx_q;
    act_d = act_q; depth_d = depth_q; steps_d = steps_q; pool_d = pool_q;
    emit_d = emit_q; first_d = first_q; refd_d = refd_q; more_d = more_q;
    r_d = r_q; out_d = out_q;
    ov_d = ov_q && !out_o.ready;
    st_we = 1'b0; st_re = 1'b0; st_addr = loc_q; st_wdata = '0;
    fr_we = 1'b0; fr_re = 1'b0; fr_addr = depth_q;
    fr_wdata = {loc_q, v_q, s_q};
    kk = kind; ok = 1'b0;
    blk = LOC_W'(KEY_COUNT) + pool_q;

    case (state_q)
      // sweep the store to empty after reset
      S_CLR: begin
        st_we = 1'b1; st_addr = clr_q; st_wdata = '0;
        clr_d = clr_q + 16'd1;
        if (clr_q == LOC_W'(STORE_DEPTH - 1)) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (in_i.valid) begin
          act_d = in_i.action; nv_d = in_i.new_value; ns_d = in_i.new_status;
          evx_d = in_i.expect_value; esx_d = in_i.expect_status;
          v_d = in_i.new_value; s_d = in_i.new_status;
          steps_d = '0; depth_d = '0; emit_d = '0; more_d = 1'b0;
          first_d = 1'b1; refd_d = 1'b0;
          state_d = S_RD;
          if (in_i.action == A_INSERT || in_i.action == A_ITERATE) begin
            loc_d = in_i.from_location ? in_i.location : {6'd0, in_i.key};
            if (!in_i.from_location && {6'd0, in_i.key} >= LOC_W'(KEY_COUNT)) begin
              r_d = mk_res({6'd0, in_i.key}, '0, '0, 1'b0, 1'b0, 1'b0, ERR_ACCESS, 1'b1);
              ret_d = RET_DONE; state_d = S_OUT;
            end
          end else begin
            loc_d = in_i.location;
          end
        end
      end

      // bounds and step check, then read the entry
      S_RD: begin
        if (loc_q >= LOC_W'(STORE_DEPTH) || steps_q >= STEP_W'(WALK_LIMIT)) begin
          r_d = mk_res(loc_q, '0, '0, 1'b0, 1'b0, 1'b0, ERR_ACCESS, 1'b1);
          ret_d = RET_DONE; state_d = S_OUT;
        end else begin
          st_re = 1'b1; steps_d = steps_q + 17'd1;
          case (act_q)
            A_INSERT:  state_d = S_INS;
            A_ITERATE: state_d = S_ITER;
            default:   state_d = S_PE;
          endcase
        end
      end

      // insert: evaluate entry at loc_q
      S_INS: begin
        first_d = 1'b0;
        if (first_q && loc_q < LOC_W'(KEY_COUNT) && kind == K_EMPTY) kk = K_END;
        case (kk)
          K_EMPTY, K_TOMB, K_END, K_TOMB_END: begin
            st_we = 1'b1;
            st_wdata = {1'b0, v_q, s_q,
                        (kk == K_EMPTY || kk == K_TOMB) ? K_LIVE : K_LIVE_END};
            if (depth_q == '0) begin
              r_d = mk_res(loc_q, nv_q, ns_q, 1'b1, 1'b0, 1'b1, ERR_NONE, 1'b1);
              ret_d = RET_DONE; state_d = S_OUT;
            end else begin
              depth_d = depth_q - 15'd1;
              fr_re = 1'b1; fr_addr = depth_q - 15'd1;
              state_d = S_POP;
            end
          end
          K_REF: begin
            loc_d = e_tgt; state_d = S_RD;
          end
          K_LIVE: begin
            loc_d = loc_q + 16'd1; state_d = S_RD;
          end
          default: begin
            // live-end: open a new block and move this entry into it
            if ({1'b0, pool_q} + {10'd0, bs} > 17'(POOL_ENTRIES)) begin
              r_d = mk_res(loc_q, '0, '0, 1'b0, 1'b0, 1'b0, ERR_POOL, 1'b1);
              ret_d = RET_DONE; state_d = S_OUT;
            end else if (depth_q >= FRAME_W'(FRAME_MAX)) begin
              r_d = mk_res(loc_q, '0, '0, 1'b0, 1'b0, 1'b0, ERR_ACCESS, 1'b1);
              ret_d = RET_DONE; state_d = S_OUT;
            end else begin
              fr_we = 1'b1;
              depth_d = depth_q + 15'd1;
              v_d = e_val; s_d = e_st;
              pool_d = pool_q + {9'd0, bs};
              mark_d = blk + {9'd0, bs} - 16'd1;
              st_re = 1'b1; st_addr = blk + {9'd0, bs} - 16'd1;
              loc_d = blk;
              state_d = S_MARK;
            end
          end
        endcase
      end

      // mark last entry of the new block as end
      S_MARK: begin
        st_we = 1'b1; st_addr = mark_q; st_wdata = {e_q[ENTRY_W-1:3], K_END};
        state_d = S_RD;
      end

      // leave a reference to where the moved entry landed, resume its owner
      S_POP: begin
        st_we = 1'b1;
        st_addr = fr_q[FRAME_BITS-1 -: LOC_W];
        st_wdata = {1'b0, {(VAL_W - LOC_W){1'b0}}, loc_q, 3'd0, K_REF};
        v_d = fr_q[ST_W +: VAL_W];
        s_d = fr_q[ST_W-1:0];
        state_d = S_RD;
      end

      S_ITER: begin
        case (kind)
          K_TOMB: begin
            loc_d = loc_q + 16'd1; state_d = S_RD;
          end
          K_REF: begin
            loc_d = e_tgt; state_d = S_RD;
          end
          K_LIVE: begin
            r_d = mk_res(loc_q, e_val, e_st, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
            loc_d = loc_q + 16'd1;
            emit_d = emit_q + 5'd1;
            if (emit_q + 5'd1 == EMIT_W'(MAX_EMIT)) begin
              more_d = 1'b1; ret_d = RET_FINAL;
            end else begin
              ret_d = RET_WALK;
            end
            state_d = S_OUT;
          end
          K_LIVE_END: begin
            r_d = mk_res(loc_q, e_val, e_st, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b0);
            ret_d = RET_FINAL; state_d = S_OUT;
          end
          default: begin
            r_d = mk_res(loc_q, '0, '0, 1'b0, 1'b0, 1'b0, ERR_NONE, 1'b1);
            ret_d = RET_DONE; state_d = S_OUT;
          end
        endcase
      end

      // per-entry actions, after following at most one reference
      S_PE: begin
        if (!refd_q && kind == K_REF) begin
          refd_d = 1'b1; loc_d = e_tgt; state_d = S_RD;
        end else begin
          ret_d = RET_DONE; state_d = S_OUT;
          r_d = mk_res(loc_q, '0, '0, 1'b0, 1'b0, 1'b0, ERR_NONE, 1'b1);
          case (act_q)
            A_READ: begin
              if (live) r_d = mk_res(loc_q, e_val, e_st, 1'b1, 1'b0, 1'b0, ERR_NONE, 1'b1);
              else if (!tomb) r_d.err = ERR_ACCESS;
            end
            A_SETST: begin
              if (live) begin
                st_we = 1'b1; st_wdata = {1'b0, e_val, ns_q, kind}; r_d.succ = 1'b1;
              end else begin
                r_d.err = ERR_ACCESS;
              end
            end
            A_CMPST: begin
              if (live) begin
                ok = (e_st == esx_q);
                st_we = ok; st_wdata = {1'b0, e_val, ns_q, kind}; r_d.succ = ok;
              end else if (!tomb) begin
                r_d.err = ERR_ACCESS;
              end
            end
            A_CUPD: begin
              ok = live && e_val == evx_q && e_st == esx_q;
              st_we = ok; st_wdata = {1'b0, nv_q, ns_q, kind}; r_d.succ = ok;
            end
            A_DELETE: begin
              if (live) begin
                st_we = 1'b1;
                st_wdata = {1'b0, e_val, e_st, (kind == K_LIVE) ? K_TOMB : K_TOMB_END};
                r_d.succ = 1'b1;
              end else begin
                r_d.err = ERR_ACCESS;
              end
            end
            default: begin
              ok = live && e_val == evx_q && e_st == esx_q;
              st_we = ok;
              st_wdata = {1'b0, e_val, e_st, (kind == K_LIVE) ? K_TOMB : K_TOMB_END};
              r_d.succ = ok;
            end
          endcase
        end
      end

      // hand the pending result to the output register
      S_OUT: begin
        if (slot_free) begin
          out_d = r_q; ov_d = 1'b1;
          case (ret_q)
            RET_WALK: state_d = S_RD;
            RET_FINAL: begin
              r_d = mk_res(loc_q, '0, '0, 1'b0, more_q, 1'b0, ERR_NONE, 1'b1);
              ret_d = RET_DONE;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ret_q   <= RET_DONE;
      clr_q   <= '0;
      pool_q  <= '0;
      ov_q    <= 1'b0;
      depth_q <= '0;
      steps_q <= '0;
      emit_q  <= '0;
      first_q <= 1'b0;
      refd_q  <= 1'b0;
      more_q  <= 1'b0;
      act_q   <= A_INSERT;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      clr_q   <= clr_d;
      pool_q  <= pool_d;
      ov_q    <= ov_d;
      depth_q <= depth_d;
      steps_q <= steps_d;
      emit_q  <= emit_d;
      first_q <= first_d;
      refd_q  <= refd_d;
      more_q  <= more_d;
      act_q   <= act_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    loc_q  <= loc_d;
    mark_q <= mark_d;
    v_q    <= v_d;
    s_q    <= s_d;
    nv_q   <= nv_d;
    ns_q   <= ns_d;
    evx_q  <= evx_d;
    esx_q  <= esx_d;
    r_q    <= r_d;
    out_q  <= out_d;
  end

  assign in_i.ready            = (state_q == S_IDLE);
  assign out_o.valid           = ov_q;
  assign out_o.result_location = out_q.loc;
  assign out_o.entry_value     = out_q.val;
  assign out_o.entry_status    = out_q.st;
  assign out_o.entry_live      = out_q.live;
  assign out_o.more_pending    = out_q.more;
  assign out_o.success         = out_q.succ;
  assign out_o.error_code      = out_q.err;
  assign out_o.last_result     = out_q.last;

endmodule

`default_nettype wire

@@ verif/chained_block_multimap_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_block_multimap_top_tb
// Drives insert, iterate and per-entry requests into the multimap, keeps a
// shadow copy of the store and pool, and checks every result in order.
// ----------------------------------------------------------------------------
module chained_block_multimap_top_tb;
  import cbm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] key;
    logic [LOC_W-1:0] location;
    logic             from_location;
    logic [VAL_W-1:0] new_value;
    logic [ST_W-1:0]  new_status;
    logic [VAL_W-1:0] expect_value;
    logic [ST_W-1:0]  expect_status;
  } mm_request_t;

  typedef struct packed {
    logic [LOC_W-1:0] loc;
    logic [VAL_W-1:0] value;
    logic [ST_W-1:0]  status;
    logic             live;
    logic             more;
    logic             success;
    logic [ERR_W-1:0] err;
    logic             last;
  } mm_result_t;

  // Shadow multimap and queue of results still owed by the block
  class mm_scoreboard;
    bit [ENTRY_W-1:0] cells[STORE_DEPTH];
    int unsigned      pool_used;
    int unsigned      blk_cfg;
    mm_result_t       owed[$];

    function new();
      pool_used = 0;
      blk_cfg   = 4;
    endfunction

    function bit [2:0] kind(bit [ENTRY_W-1:0] e);
      return (e[2:0] == 3'd7) ? K_END : e[2:0];
    endfunction

    function bit [ENTRY_W-1:0] pack(bit [VAL_W-1:0] v, bit [2:0] s, bit [2:0] k);
      return {1'b0, v, s, k};
    endfunction

    function int unsigned target(bit [ENTRY_W-1:0] e);
      return (e[62:6] >= STORE_DEPTH) ? STORE_DEPTH : int'(e[62:6]);
    endfunction

    function int unsigned blk();
      if (blk_cfg < 2) return 2;
      if (blk_cfg > 64) return 64;
      return blk_cfg;
    endfunction

    function void owe(int unsigned loc, bit [VAL_W-1:0] v, bit [2:0] s, bit live,
                      bit more, bit succ, bit [ERR_W-1:0] err, bit last);
      mm_result_t r;
      r = '{loc[LOC_W-1:0], v, s, live, more, succ, err, last};
      owed.push_back(r);
    endfunction

    // empty primary slot becomes an end mark before an insert lands
    function void mark_primary(int unsigned loc);
      if (loc < KEY_COUNT && kind(cells[loc]) == K_EMPTY) cells[loc][2:0] = K_END;
    endfunction

    function bit [ERR_W-1:0] insert(int unsigned loc, bit [VAL_W-1:0] v, bit [2:0] s,
                                    output int unsigned where);
      int unsigned      steps;
      int unsigned      bs;
      int unsigned      b;
      bit [ENTRY_W-1:0] e;
      bit [2:0]         k;
      int unsigned      f_loc[$];
      bit [VAL_W-1:0]   f_val[$];
      bit [2:0]         f_st[$];
      steps = 0;
      mark_primary(loc);
      forever begin
        steps++;
        if (loc >= STORE_DEPTH || steps > WALK_LIMIT) begin
          where = loc;
          return ERR_ACCESS;
        end
        e = cells[loc];
        k = kind(e);
        if (k == K_EMPTY || k == K_TOMB || k == K_END || k == K_TOMB_END) begin
          cells[loc] = pack(v, s, (k == K_EMPTY || k == K_TOMB) ? K_LIVE : K_LIVE_END);
          if (f_loc.size() == 0) begin
            where = loc;
            return ERR_NONE;
          end
          // moved entry landed: leave a reference, resume the pending insert
          cells[f_loc[$]] = pack(VAL_W'(loc), 3'd0, K_REF);
          v = f_val.pop_back();
          s = f_st.pop_back();
          void'(f_loc.pop_back());
          mark_primary(loc);
        end else if (k == K_REF) begin
          loc = target(e);
        end else if (k == K_LIVE) begin
          loc++;
        end else begin
          bs = blk();
          if (pool_used + bs > POOL_ENTRIES) begin
            where = loc;
            return ERR_POOL;
          end
          if (f_loc.size() >= FRAME_MAX) begin
            where = loc;
            return ERR_ACCESS;
          end
          b = KEY_COUNT + pool_used;
          pool_used += bs;
          cells[b + bs - 1][2:0] = K_END;
          f_loc.push_back(loc);
          f_val.push_back(v);
          f_st.push_back(s);
          v   = e[62:6];
          s   = e[5:3];
          loc = b;
          mark_primary(loc);
        end
      end
    endfunction

    function void iterate(int unsigned loc);
      int unsigned      n;
      int unsigned      steps;
      bit [ENTRY_W-1:0] e;
      bit [2:0]         k;
      n     = 0;
      steps = 0;
      forever begin
        steps++;
        if (loc >= STORE_DEPTH || steps > WALK_LIMIT) begin
          owe(loc, 0, 0, 0, 0, 0, ERR_ACCESS, 1);
          return;
        end
        e = cells[loc];
        k = kind(e);
        if (k == K_TOMB) begin
          loc++;
        end else if (k == K_REF) begin
          loc = target(e);
        end else if (k == K_LIVE) begin
          owe(loc, e[62:6], e[5:3], 1, 0, 0, ERR_NONE, 0);
          n++;
          loc++;
          if (n >= MAX_EMIT) begin
            owe(loc, 0, 0, 0, 1, 0, ERR_NONE, 1);
            return;
          end
        end else if (k == K_LIVE_END) begin
          owe(loc, e[62:6], e[5:3], 1, 0, 0, ERR_NONE, 0);
          owe(loc, 0, 0, 0, 0, 0, ERR_NONE, 1);
          return;
        end else begin
          owe(loc, 0, 0, 0, 0, 0, ERR_NONE, 1);
          return;
        end
      end
    endfunction

    // live view of a location after one reference hop, used to aim compares
    function bit peek(int unsigned loc, output bit [VAL_W-1:0] v, output bit [2:0] s);
      v = 0;
      s = 0;
      if (loc >= STORE_DEPTH) return 0;
      if (kind(cells[loc]) == K_REF) loc = target(cells[loc]);
      if (loc >= STORE_DEPTH) return 0;
      v = cells[loc][62:6];
      s = cells[loc][5:3];
      return 1;
    endfunction

    // accepted request: update shadow state, queue what it must produce
    function void note_request(mm_request_t r);
      int unsigned      loc;
      int unsigned      where;
      bit [ERR_W-1:0]   err;
      bit [ENTRY_W-1:0] e;
      bit [2:0]         k;
      bit               live;
      bit               tomb;
      bit               ok;
      if (r.action == A_INSERT || r.action == A_ITERATE) begin
        loc = r.from_location ? r.location : r.key;
        if (r.action == A_ITERATE) begin
          iterate(loc);
          return;
        end
        err = insert(loc, r.new_value, r.new_status, where);
        if (err == ERR_NONE) owe(where, r.new_value, r.new_status, 1, 0, 1, ERR_NONE, 1);
        else owe(where, 0, 0, 0, 0, 0, err, 1);
        return;
      end
      loc = r.location;
      if (loc >= STORE_DEPTH) begin
        owe(loc, 0, 0, 0, 0, 0, ERR_ACCESS, 1);
        return;
      end
      if (kind(cells[loc]) == K_REF) begin
        loc = target(cells[loc]);
        if (loc >= STORE_DEPTH) begin
          owe(loc, 0, 0, 0, 0, 0, ERR_ACCESS, 1);
          return;
        end
      end
      e    = cells[loc];
      k    = kind(e);
      live = (k == K_LIVE || k == K_LIVE_END);
      tomb = (k == K_TOMB || k == K_TOMB_END);
      case (r.action)
        A_READ: begin
          if (live) owe(loc, e[62:6], e[5:3], 1, 0, 0, ERR_NONE, 1);
          else owe(loc, 0, 0, 0, 0, 0, tomb ? ERR_NONE : ERR_ACCESS, 1);
        end
        A_SETST: begin
          if (live) cells[loc] = pack(e[62:6], r.new_status, k);
          owe(loc, 0, 0, 0, 0, live, live ? ERR_NONE : ERR_ACCESS, 1);
        end
        A_CMPST: begin
          ok = live && e[5:3] == r.expect_status;
          if (ok) cells[loc] = pack(e[62:6], r.new_status, k);
          owe(loc, 0, 0, 0, 0, ok, (live || tomb) ? ERR_NONE : ERR_ACCESS, 1);
        end
        A_CUPD: begin
          ok = live && e[62:6] == r.expect_value && e[5:3] == r.expect_status;
          if (ok) cells[loc] = pack(r.new_value, r.new_status, k);
          owe(loc, 0, 0, 0, 0, ok, ERR_NONE, 1);
        end
        A_DELETE: begin
          if (live) cells[loc] = pack(e[62:6], e[5:3], k == K_LIVE ? K_TOMB : K_TOMB_END);
          owe(loc, 0, 0, 0, 0, live, live ? ERR_NONE : ERR_ACCESS, 1);
        end
        default: begin
          ok = live && e[62:6] == r.expect_value && e[5:3] == r.expect_status;
          if (ok) cells[loc] = pack(e[62:6], e[5:3], k == K_LIVE ? K_TOMB : K_TOMB_END);
          owe(loc, 0, 0, 0, 0, ok, ERR_NONE, 1);
        end
      endcase
    endfunction

    // returns an empty string on a match, else a description of the miss
    function string check_result(mm_result_t got);
      mm_result_t want;
      string      msg;
      if (owed.size() == 0) return $sformatf("result with nothing owed: %p", got);
      want = owed.pop_front();
      msg  = "";
      if (got.loc !== want.loc)
        msg = {msg, $sformatf(" loc %0d/%0d", got.loc, want.loc)};
      if (got.value !== want.value)
        msg = {msg, $sformatf(" value %h/%h", got.value, want.value)};
      if (got.status !== want.status)
        msg = {msg, $sformatf(" status %0d/%0d", got.status, want.status)};
      if (got.live !== want.live) msg = {msg, " live"};
      if (got.more !== want.more) msg = {msg, " more"};
      if (got.success !== want.success) msg = {msg, " success"};
      if (got.err !== want.err) msg = {msg, $sformatf(" err %0d/%0d", got.err, want.err)};
      if (got.last !== want.last) msg = {msg, " last"};
      return msg;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cbm_in_if  req_if ();
  cbm_out_if rsp_if ();

  chained_block_multimap_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  mm_scoreboard sb = new();
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  src_idle = 0;
  int unsigned  sink_idle = 0;
  int unsigned  live_locs[$];
  int unsigned  resume_locs[$];

  always #1 clk_i = ~clk_i;

  task automatic report(string msg);
    errors++;
    $display("MISMATCH @%0d:%s", cycles, msg);
  endtask

  // run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("chained_block_multimap_top_tb: done, errors");
      $finish;
    end
  end

  // result side: check accepted results, stall at random
  always @(posedge clk_i) begin
    mm_result_t got;
    string      msg;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.result_location, rsp_if.entry_value, rsp_if.entry_status,
              rsp_if.entry_live, rsp_if.more_pending, rsp_if.success,
              rsp_if.error_code, rsp_if.last_result};
      msg = sb.check_result(got);
      if (msg != "") report(msg);
      if (rsp_if.entry_live) live_locs.push_back(rsp_if.result_location);
      if (rsp_if.more_pending) resume_locs.push_back(rsp_if.result_location);
    end
    rsp_if.ready <= ($urandom_range(99) >= sink_idle);
  end

  // APB write: setup then access phase
  task automatic write_blk_len(int unsigned value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'd0;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.blk_cfg = value & 32'h7f;
  endtask

  task automatic send(mm_request_t r);
    if ($urandom_range(99) < src_idle) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    req_if.valid         <= 1'b1;
    req_if.action        <= r.action;
    req_if.key           <= r.key;
    req_if.location      <= r.location;
    req_if.from_location <= r.from_location;
    req_if.new_value     <= r.new_value;
    req_if.new_status    <= r.new_status;
    req_if.expect_value  <= r.expect_value;
    req_if.expect_status <= r.expect_status;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
  endtask

  // block is idle once all owed results arrived and its tail has passed
  task automatic drain();
    @(posedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic mm_request_t mk(logic [2:0] act, int unsigned key, int unsigned loc,
                                     bit from, logic [VAL_W-1:0] nv, logic [2:0] ns,
                                     logic [VAL_W-1:0] ev, logic [2:0] es);
    mm_request_t r;
    r = '{act, key[KEY_W-1:0], loc[LOC_W-1:0], from, nv, ns, ev, es};
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    return VAL_W'({$urandom, $urandom});
  endfunction

  // mostly chains on a few keys, compares aimed at current contents
  function automatic mm_request_t rand_request();
    mm_request_t    r;
    int unsigned    p;
    bit [VAL_W-1:0] v;
    bit [2:0]       s;
    r.action        = ACT_W'($urandom_range(7));
    r.key           = KEY_W'($urandom_range(3));
    r.location      = LOC_W'($urandom_range(65535));
    r.from_location = 1'($urandom_range(1));
    r.new_value     = rand_value();
    r.new_status    = ST_W'($urandom_range(7));
    r.expect_value  = rand_value();
    r.expect_status = ST_W'($urandom_range(7));
    if ($urandom_range(9) == 0) r.key = KEY_W'($urandom_range(1023));
    p = $urandom_range(99);
    if (p < 35) begin
      r.action        = A_INSERT;
      r.from_location = 1'b0;
      if (live_locs.size() != 0 && $urandom_range(9) == 0) begin
        r.from_location = 1'b1;
        r.location      = LOC_W'(live_locs[$urandom_range(live_locs.size() - 1)]);
      end
    end else if (p < 50) begin
      r.action        = A_ITERATE;
      r.from_location = 1'b0;
      if (resume_locs.size() != 0 && $urandom_range(1)) begin
        r.from_location = 1'b1;
        r.location      = LOC_W'(resume_locs.pop_front());
      end
    end else begin
      r.action = ACT_W'($urandom_range(A_READ, A_CDELETE));
      if (live_locs.size() != 0 && $urandom_range(4) != 0)
        r.location = LOC_W'(live_locs[$urandom_range(live_locs.size() - 1)]);
      if ($urandom_range(4) < 3 && sb.peek(r.location, v, s)) begin
        r.expect_value  = v;
        r.expect_status = s;
      end
    end
    return r;
  endfunction

  initial begin
    logic [VAL_W-1:0] ones;
    ones = '1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.action = A_INSERT;
    req_if.key = '0;
    req_if.location = '0;
    req_if.from_location = 1'b0;
    req_if.new_value = '0;
    req_if.new_status = '0;
    req_if.expect_value = '0;
    req_if.expect_status = '0;
    rsp_if.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero clamps to the smallest block, so chains overflow fast
    write_blk_len(0);
    src_idle  = 28;
    sink_idle = 69;

    // directed: growth of key 0, then every action and its corner cases
    send(mk(A_INSERT, 0, 0, 0, ones, 3'd7, 0, 0));
    send(mk(A_INSERT, 0, 0, 0, '0, 3'd0, 0, 0));
    send(mk(A_INSERT, 0, 0, 0, 57'h123, 3'd5, 0, 0));
    send(mk(A_INSERT, 0, 0, 0, 57'h456, 3'd2, 0, 0));
    send(mk(A_ITERATE, 0, 0, 0, 0, 0, 0, 0));
    send(mk(A_READ, 0, 0, 0, 0, 0, 0, 0));
    send(mk(A_READ, 0, 1024, 0, 0, 0, 0, 0));
    send(mk(A_SETST, 0, 1024, 0, 0, 3'd6, 0, 0));
    send(mk(A_CMPST, 0, 1024, 0, 0, 3'd1, 0, 3'd6));
    send(mk(A_CUPD, 0, 1024, 0, ones, 3'd4, ones, 3'd1));
    send(mk(A_CUPD, 0, 1025, 0, ones, 3'd4, 57'h5, 3'd3));
    send(mk(A_DELETE, 0, 1025, 0, 0, 0, 0, 0));
    send(mk(A_READ, 0, 1025, 0, 0, 0, 0, 0));
    send(mk(A_CMPST, 0, 1025, 0, 0, 0, 0, 0));
    send(mk(A_DELETE, 0, 1025, 0, 0, 0, 0, 0));
    send(mk(A_CDELETE, 0, 1026, 0, 0, 0, 57'h1, 3'd1));
    send(mk(A_READ, 0, 5, 0, 0, 0, 0, 0));
    send(mk(A_SETST, 0, 5, 0, 0, 3'd1, 0, 0));
    send(mk(A_CMPST, 0, 7, 0, 0, 3'd1, 0, 0));
    send(mk(A_READ, 0, 65535, 1, 0, 0, 0, 0));
    send(mk(A_ITERATE, 0, 65535, 1, 0, 0, 0, 0));
    send(mk(A_INSERT, 0, 40000, 1, ones, 3'd7, 0, 0));
    send(mk(A_INSERT, 1023, 0, 0, 57'h2aa, 3'd3, 0, 0));
    send(mk(A_ITERATE, 1023, 0, 0, 0, 0, 0, 0));
    send(mk(A_ITERATE, 5, 0, 0, 0, 0, 0, 0));

    // random phases: shifting idle mix and block sizes
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: write_blk_len(127);
        1: write_blk_len($urandom_range(2, 64));
        default: write_blk_len(2);
      endcase
      src_idle  = (ph == 0) ? 28 : (ph == 1) ? 69 : 0;
      sink_idle = (ph == 0) ? 69 : (ph == 1) ? 28 : 0;
      repeat (32) send(rand_request());
    end

    drain();
    if (errors == 0) begin
      $display("chained_block_multimap_top_tb: done, clean");
    end else begin
      $display("chained_block_multimap_top_tb: done, errors");
    end
    $finish;
  end

endmodule
